[rtl/pbrr_pkg.sv]
package pbrr_pkg;

    // Default sizes of the scheduler.
    localparam int MAX_TASKS_DEF   = 64;
    localparam int PRIO_LEVELS_DEF = 256;

    // Field widths fixed by the item format.
    localparam int MODE_W  = 2;
    localparam int TASKID_W = 6;
    localparam int LEVEL_W = 8;

    // The bitmap is kept and scanned one word at a time.
    localparam int WORD_BITS = 32;
    localparam int BIT_SEL_W = 5;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_READY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNREADY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PICK    = 2'd2;

    // Commands from the sequencer to the level map.
    typedef struct packed {
        logic               set;
        logic               clr;
        logic [LEVEL_W-1:0] upd_lvl;
        logic               scan_start;
        logic               scan_step;
    } t_map_ctl;

    // Status from the level map back to the sequencer.
    typedef struct packed {
        logic               test_bit;
        logic               hit;
        logic               last;
        logic [LEVEL_W-1:0] found_lvl;
    } t_map_stat;

endpackage

[rtl/pbrr_level_map.sv]
module pbrr_level_map
    import pbrr_pkg::*;
#(
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_map_ctl           i_ctl,
    input  logic [LEVEL_W-1:0] i_test_lvl,
    output t_map_stat          o_stat
);

    localparam int WORDS  = (PRIORITY_LEVELS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [WORD_BITS-1:0] r_bitmap [WORDS];
    logic [WIDX_W-1:0]    r_widx;

    logic [WIDX_W-1:0]    upd_word;
    logic [WIDX_W-1:0]    test_word;
    logic [WORD_BITS-1:0] scan_word;
    logic [BIT_SEL_W-1:0] scan_bit;
    logic                 test_in_range;

    // Position of the highest set bit of one bitmap word.
    function automatic logic [BIT_SEL_W-1:0] hi_bit(input logic [WORD_BITS-1:0] w);
        logic [BIT_SEL_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                pos = BIT_SEL_W'(i);
            end
        end
        return pos;
    endfunction

    assign upd_word  = WIDX_W'(i_ctl.upd_lvl >> BIT_SEL_W);
    assign test_word = WIDX_W'(i_test_lvl >> BIT_SEL_W);

    // One bit per non-empty level; the sequencer only touches levels in range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORDS; w++) begin
                r_bitmap[w] <= '0;
            end
        end else if (i_ctl.set) begin
            r_bitmap[upd_word][i_ctl.upd_lvl[BIT_SEL_W-1:0]] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_bitmap[upd_word][i_ctl.upd_lvl[BIT_SEL_W-1:0]] <= 1'b0;
        end
    end

    // Scan pointer walks from the top word down, one word per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
        end else if (i_ctl.scan_start) begin
            r_widx <= WIDX_W'(WORDS - 1);
        end else if (i_ctl.scan_step) begin
            r_widx <= r_widx - 1'b1;
        end
    end

    assign scan_word     = r_bitmap[r_widx];
    assign scan_bit      = hi_bit(scan_word);
    assign test_in_range = ({1'b0, i_test_lvl} < 9'(PRIORITY_LEVELS));

    always_comb begin
        o_stat.test_bit  = test_in_range && r_bitmap[test_word][i_test_lvl[BIT_SEL_W-1:0]];
        o_stat.hit       = |scan_word;
        o_stat.last      = (r_widx == '0);
        o_stat.found_lvl = LEVEL_W'({r_widx, scan_bit});
    end

endmodule

[rtl/priority_bitmap_round_robin_scheduler_core.sv]
// Priority bitmap scheduler with one round-robin task queue per priority level.
// Input channel: an item is taken at a rising edge with start high and busy low.
// i_mode selects ready (append task), unready (unlink task) or pick (reschedule).
// Result channel: o_done is high for exactly one cycle per item, and the running
// task, switch_done and pending_out are valid in that cycle only. The receiver
// cannot stall; each result must be captured in its strobe cycle.
// States to the strobe: S_LOOK, S_DONE for a ready to an empty level, an unready,
// a pick that does nothing or an unused mode; S_LOOK, S_TAIL, S_LINK, S_DONE for
// a ready to a non-empty level; for a pick, S_LOOK, S_ROT if the running level is
// still set, S_SCAN over up to W = ceil(PRIORITY_LEVELS / 32) bitmap words,
// scanned one word per cycle by a single priority encoder, S_SEL if a level is
// found, then S_DONE. Each link memory has one read and one write port, so a
// ready append is spread over three memory steps. busy stays low from the strobe
// cycle on, so the next item can follow at once. Reset: synchronous, active low.
// After reset a clearing pass zeroes the per-task queue state; busy is high
// during it. No task runs and no reschedule is pending after reset.
module priority_bitmap_round_robin_scheduler_core
    import pbrr_pkg::*;
#(
    parameter int MAX_TASKS       = MAX_TASKS_DEF,
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [TASKID_W-1:0]        i_task_id,
    input  logic signed [LEVEL_W-1:0]  i_task_priority,
    input  logic                       i_preempt_blocked,
    output logic                       o_done,
    output logic                       o_running_valid,
    output logic [TASKID_W-1:0]        o_running_task,
    output logic signed [LEVEL_W-1:0]  o_running_priority,
    output logic                       o_switch_done,
    output logic                       o_pending_out
);

    localparam int TASK_W = $clog2(MAX_TASKS);
    localparam int LIDX_W = $clog2(PRIORITY_LEVELS);

    typedef struct packed {
        logic               queued;
        logic [LEVEL_W-1:0] level;
    } t_task_info;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b0_0000_0001,
        S_IDLE  = 9'b0_0000_0010,
        S_LOOK  = 9'b0_0000_0100,
        S_TAIL  = 9'b0_0000_1000,
        S_LINK  = 9'b0_0001_0000,
        S_ROT   = 9'b0_0010_0000,
        S_SCAN  = 9'b0_0100_0000,
        S_SEL   = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Latched item.
    logic [MODE_W-1:0]  r_mode;
    logic [TASK_W-1:0]  r_task;
    logic [LEVEL_W-1:0] r_lvl;
    logic               r_blocked;
    logic               r_ok;

    // Scheduler state.
    logic               r_cur_present;
    logic [TASK_W-1:0]  r_cur_task;
    logic [LEVEL_W-1:0] r_cur_level;
    logic               r_pending;
    logic               r_switch;

    // Work registers.
    logic [TASK_W-1:0]  r_h;
    logic [LEVEL_W-1:0] r_found;
    logic [TASK_W-1:0]  r_clr;

    // Result registers.
    logic               r_done;
    logic               r_out_valid;
    logic [TASK_W-1:0]  r_out_task;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_switch;
    logic               r_out_pending;

    // Memories and their ports.
    logic [TASK_W-1:0] head_mem [PRIORITY_LEVELS];
    logic [TASK_W-1:0] next_mem [MAX_TASKS];
    logic [TASK_W-1:0] prev_mem [MAX_TASKS];
    t_task_info        info_mem [MAX_TASKS];

    logic [TASK_W-1:0] r_head_q, r_next_q, r_prev_q;
    t_task_info        r_info_q;

    logic              head_we, next_we, prev_we, info_we;
    logic [LIDX_W-1:0] head_wa, head_ra;
    logic [TASK_W-1:0] head_wd;
    logic [TASK_W-1:0] next_wa, next_wd, next_ra;
    logic [TASK_W-1:0] prev_wa, prev_wd, prev_ra;
    logic [TASK_W-1:0] info_wa, info_ra;
    t_task_info        info_wd;

    t_map_ctl           map_ctl;
    t_map_stat          map_stat;
    logic [LEVEL_W-1:0] test_lvl;

    logic               accept;
    logic [LEVEL_W-1:0] in_lvl;
    logic [TASK_W-1:0]  in_task;
    logic               in_ok;
    logic               pick_go;

    assign accept  = start && (r_state == S_IDLE);
    assign in_lvl  = {~i_task_priority[LEVEL_W-1], i_task_priority[LEVEL_W-2:0]};
    assign in_task = TASK_W'(i_task_id);
    assign in_ok   = ({5'd0, i_task_id} < 11'(MAX_TASKS)) &&
                     ({1'b0, in_lvl} < 9'(PRIORITY_LEVELS));
    assign pick_go = r_pending && !(r_cur_present && r_blocked);
    assign test_lvl = (r_mode == MODE_PICK) ? r_cur_level : r_lvl;

    pbrr_level_map #(
        .PRIORITY_LEVELS(PRIORITY_LEVELS)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (map_ctl),
        .i_test_lvl (test_lvl),
        .o_stat     (map_stat)
    );

    // Sequencer: next state, memory ports and level map commands.
    always_comb begin
        n_state = r_state;
        head_we = 1'b0;
        head_wa = LIDX_W'(r_lvl);
        head_wd = r_task;
        head_ra = LIDX_W'(r_cur_level);
        next_we = 1'b0;
        next_wa = r_task;
        next_wd = r_task;
        next_ra = r_task;
        prev_we = 1'b0;
        prev_wa = r_task;
        prev_wd = r_task;
        prev_ra = r_task;
        info_we = 1'b0;
        info_wa = r_task;
        info_wd = '{queued: 1'b1, level: r_lvl};
        info_ra = in_task;
        map_ctl = '{set: 1'b0, clr: 1'b0, upd_lvl: r_lvl, scan_start: 1'b0, scan_step: 1'b0};

        case (r_state)
            S_CLEAR: begin
                info_we = 1'b1;
                info_wa = r_clr;
                info_wd = '{queued: 1'b0, level: '0};
                if (r_clr == TASK_W'(MAX_TASKS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Reads for the incoming item are issued from the input fields.
            S_IDLE: begin
                head_ra = (i_mode == MODE_PICK) ? LIDX_W'(r_cur_level) : LIDX_W'(in_lvl);
                next_ra = in_task;
                prev_ra = in_task;
                if (accept) begin
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                map_ctl.scan_start = 1'b1;
                n_state = S_DONE;
                case (r_mode)
                    MODE_READY: begin
                        if (r_ok && !r_info_q.queued) begin
                            info_we = 1'b1;
                            if (!map_stat.test_bit) begin
                                // First task of the level links to itself.
                                head_we     = 1'b1;
                                next_we     = 1'b1;
                                prev_we     = 1'b1;
                                map_ctl.set = 1'b1;
                            end else begin
                                // Append before the head; fetch the tail next.
                                next_we = 1'b1;
                                next_wd = r_head_q;
                                prev_ra = r_head_q;
                                n_state = S_TAIL;
                            end
                        end
                    end
                    MODE_UNREADY: begin
                        if (r_ok && r_info_q.queued && (r_info_q.level == r_lvl)) begin
                            info_we = 1'b1;
                            info_wd = '{queued: 1'b0, level: r_lvl};
                            if (r_next_q == r_task) begin
                                map_ctl.clr = 1'b1;
                            end else begin
                                next_we = 1'b1;
                                next_wa = r_prev_q;
                                next_wd = r_next_q;
                                prev_we = 1'b1;
                                prev_wa = r_next_q;
                                prev_wd = r_prev_q;
                                if (r_head_q == r_task) begin
                                    head_we = 1'b1;
                                    head_wd = r_next_q;
                                end
                            end
                        end
                    end
                    MODE_PICK: begin
                        if (pick_go) begin
                            if (r_cur_present && map_stat.test_bit) begin
                                next_ra = r_head_q;
                                n_state = S_ROT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Old tail now points at the new task.
            S_TAIL: begin
                next_we = 1'b1;
                next_wa = r_prev_q;
                prev_we = 1'b1;
                prev_wd = r_prev_q;
                n_state = S_LINK;
            end

            S_LINK: begin
                prev_we = 1'b1;
                prev_wa = r_h;
                n_state = S_DONE;
            end

            // Rotate the current level by one.
            S_ROT: begin
                head_we = 1'b1;
                head_wa = LIDX_W'(r_cur_level);
                head_wd = r_next_q;
                n_state = S_SCAN;
            end

            S_SCAN: begin
                head_ra = LIDX_W'(map_stat.found_lvl);
                if (map_stat.hit) begin
                    n_state = S_SEL;
                end else if (map_stat.last) begin
                    n_state = S_DONE;
                end else begin
                    map_ctl.scan_step = 1'b1;
                end
            end

            S_SEL: begin
                n_state = S_DONE;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        r_head_q <= head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        r_next_q <= next_mem[next_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        r_prev_q <= prev_mem[prev_ra];
    end

    always_ff @(posedge i_clk) begin
        if (info_we) begin
            info_mem[info_wa] <= info_wd;
        end
        r_info_q <= info_mem[info_ra];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_cur_present <= 1'b0;
            r_cur_task    <= '0;
            r_cur_level   <= '0;
            r_pending     <= 1'b0;
            r_switch      <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (accept) begin
                r_switch <= 1'b0;
            end
            if ((r_state == S_LOOK) &&
                ((r_mode == MODE_READY) || (r_mode == MODE_UNREADY))) begin
                r_pending <= 1'b1;
            end
            // Nothing ready: no task runs.
            if ((r_state == S_SCAN) && !map_stat.hit && map_stat.last) begin
                r_cur_present <= 1'b0;
                r_cur_task    <= '0;
                r_cur_level   <= '0;
                r_pending     <= 1'b0;
                r_switch      <= 1'b1;
            end
            if (r_state == S_SEL) begin
                r_cur_present <= 1'b1;
                r_cur_task    <= r_head_q;
                r_cur_level   <= r_found;
                r_pending     <= 1'b0;
                r_switch      <= 1'b1;
            end
        end
    end

    // Item and work registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= i_mode;
            r_task    <= in_task;
            r_lvl     <= in_lvl;
            r_blocked <= i_preempt_blocked;
            r_ok      <= in_ok;
        end
        if (r_state == S_LOOK) begin
            r_h <= r_head_q;
        end
        if (r_state == S_SCAN) begin
            r_found <= map_stat.found_lvl;
        end
    end

    // Result registers, loaded once per item.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_out_valid   <= r_cur_present;
            r_out_task    <= r_cur_task;
            r_out_level   <= r_cur_level;
            r_out_switch  <= r_switch;
            r_out_pending <= r_pending;
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_running_valid    = r_out_valid;
    assign o_running_task     = r_out_valid ? TASKID_W'(r_out_task) : '0;
    assign o_running_priority = r_out_valid ?
                                {~r_out_level[LEVEL_W-1], r_out_level[LEVEL_W-2:0]} : '0;
    assign o_switch_done      = r_out_switch;
    assign o_pending_out      = r_out_pending;

endmodule
